// ----- design/tracker_pattern_unpacker_macros.svh -----
// Assertion macros for the tracker pattern unpacker.
// Needs a clock named clock and an active high reset named reset in scope.
`ifndef TRACKER_PATTERN_UNPACKER_MACROS_SVH
`define TRACKER_PATTERN_UNPACKER_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define TPU_ASSERT_NOW(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |-> (effect)) \
      else $error(msg);

// Check a consequence in the cycle after its cause
`define TPU_ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

// ----- design/tpu_pkg.sv -----
// Shared types and constants of the tracker pattern unpacker.
// No dependencies; used by tpu_cell_format and tracker_pattern_unpacker.
package tpu_pkg;

   // Register indexes of the configuration port
   typedef enum logic {
      CSR_CHANNEL_COUNT = 1'b0,
      CSR_ROW_COUNT     = 1'b1
   } csr_index_type;

   // Kind of note carried by a decoded cell
   typedef enum logic [1:0] {
      NOTE_PITCHED = 2'd0,
      NOTE_EMPTY   = 2'd1,
      NOTE_STOP    = 2'd2
   } note_kind_type;

   localparam logic [7:0] NOTE_BYTE_STOP   = 8'd97;
   localparam logic [7:0] INSTRUMENT_NONE  = 8'hFF;
   localparam logic [7:0] VOLUME_LOW       = 8'd16;
   localparam logic [7:0] VOLUME_HIGH      = 8'd80;
   localparam logic [7:0] VOLUME_FULL      = 8'hFF;
   localparam logic [4:0] FIELDS_AFTER_NOTE = 5'b11110;

   // Field bits of a flag byte
   localparam int FLAG_NOTE       = 0;
   localparam int FLAG_INSTRUMENT = 1;
   localparam int FLAG_VOLUME     = 2;
   localparam int FLAG_EFFECT     = 3;
   localparam int FLAG_MARKER     = 7;

   // Decoded contents of one cell, without its position
   typedef struct packed {
      note_kind_type note_kind;
      logic [7:0]    note_value;
      logic          instrument_present;
      logic [7:0]    instrument_value;
      logic          volume_set;
      logic [7:0]    volume_value;
      logic [7:0]    effect_kind;
      logic [7:0]    effect_argument;
   } cell_fields_type;

endpackage

// ----- design/tpu_cell_format.sv -----
// Turns the raw bytes gathered for one cell into its decoded fields.
// Depends on tpu_pkg. Purely combinational.
module tpu_cell_format (
   input  logic [7:0]               note_byte,
   input  logic [7:0]               instrument_byte,
   input  logic [7:0]               volume_byte,
   input  logic [7:0]               effect_byte,
   input  logic [7:0]               argument_byte,
   output tpu_pkg::cell_fields_type fields
);
   import tpu_pkg::*;

   logic [7:0] volume_offset;
   logic [9:0] volume_scaled;

   // Scale the volume column: offset from the low bound, times four
   assign volume_offset = volume_byte - VOLUME_LOW;
   assign volume_scaled = {volume_offset, 2'b00};

   always_comb begin
      fields = '0;

      // Map note: zero is empty, the stop code stops, the rest drop by one
      if (note_byte == 8'd0) begin
         fields.note_kind  = NOTE_EMPTY;
         fields.note_value = 8'd0;
      end else if (note_byte == NOTE_BYTE_STOP) begin
         fields.note_kind  = NOTE_STOP;
         fields.note_value = 8'd0;
      end else begin
         fields.note_kind  = NOTE_PITCHED;
         fields.note_value = note_byte - 8'd1;
      end

      // Instrument: the all ones byte means none was given
      if (instrument_byte != INSTRUMENT_NONE) begin
         fields.instrument_present = 1'b1;
         fields.instrument_value   = instrument_byte - 8'd1;
      end else begin
         fields.instrument_present = 1'b0;
         fields.instrument_value   = 8'd0;
      end

      // Volume: clip the scaled range, zero means full, others not set
      if (volume_byte >= VOLUME_LOW && volume_byte <= VOLUME_HIGH) begin
         fields.volume_set   = 1'b1;
         fields.volume_value = (volume_scaled > 10'd255) ? VOLUME_FULL : volume_scaled[7:0];
      end else if (volume_byte == 8'd0) begin
         fields.volume_set   = 1'b1;
         fields.volume_value = VOLUME_FULL;
      end else begin
         fields.volume_set   = 1'b0;
         fields.volume_value = 8'd0;
      end

      fields.effect_kind     = effect_byte;
      fields.effect_argument = argument_byte;
   end

endmodule

// ----- design/tracker_pattern_unpacker.sv -----
// Tracker pattern unpacker: top level.
// Depends on tpu_pkg, tpu_cell_format and tracker_pattern_unpacker_macros.svh.
//
// Usage:
//   The req channel carries packed pattern data, one byte a beat, with
//   req_pattern_start set on the first byte of each pattern. The rsp channel
//   gives one decoded cell a beat, in row-major order with the channel
//   running fastest, and flags the final cell with rsp_last_of_pattern.
//   Bytes after the final cell are dropped until the next pattern start.
//   The csr port sets channels per row and rows per pattern; write it only
//   while the block is idle.
// Timing:
//   One byte is taken every cycle unless stalled. The cell decoded from a cell's
//   last byte is presented on rsp in the cycle after that byte's beat, from the
//   result register. The byte state and the result register form a single stage.
// Stall:
//   While a result waits and rsp_ready is low, req_ready is low; as soon as
//   the result is taken, a new byte is accepted in the same cycle.
// Reset:
//   Synchronous, active high. Counters and the partial cell clear, rsp goes
//   invalid, channel count returns to 1 and row count to 64.
`include "tracker_pattern_unpacker_macros.svh"

module tracker_pattern_unpacker #(
   parameter int MAX_CHANNELS = 32,
   parameter int MAX_ROWS     = 256
) (
   input  logic       clock,
   input  logic       reset,
   // configuration port
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [8:0] csr_write_data,
   // byte stream
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_pattern_start,
   // decoded cells
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_row_index,
   output logic [4:0] rsp_channel_index,
   output logic [1:0] rsp_note_kind,
   output logic [7:0] rsp_note_value,
   output logic       rsp_instrument_present,
   output logic [7:0] rsp_instrument_value,
   output logic       rsp_volume_set,
   output logic [7:0] rsp_volume_value,
   output logic [7:0] rsp_effect_kind,
   output logic [7:0] rsp_effect_argument,
   output logic       rsp_last_of_pattern
);
   import tpu_pkg::*;

   localparam int CHAN_LIMIT = (MAX_CHANNELS > 32) ? 32 : MAX_CHANNELS;
   localparam int ROW_LIMIT  = (MAX_ROWS > 256) ? 256 : MAX_ROWS;

   // configuration registers
   logic [5:0] channel_count_ff;
   logic [8:0] row_count_ff;

   // parse state
   logic [4:0] pending_ff,   pending_in;
   logic       cell_open_ff, cell_open_in;
   logic [4:0] channel_ff,   channel_in;
   logic [7:0] row_ff,       row_in;
   logic       done_ff,      done_in;
   logic [7:0] note_ff,      note_in;
   logic [7:0] instrument_ff, instrument_in;
   logic [7:0] volume_ff,    volume_in;
   logic [7:0] effect_ff,    effect_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_row_ff;
   logic [4:0]      rsp_channel_ff;
   logic            rsp_last_ff;
   cell_fields_type rsp_cell_ff;

   logic            accept;
   logic            emit;
   logic [7:0]      argument;
   logic [5:0]      chans;
   logic [8:0]      rows;
   logic            last_channel;
   logic            last_row;
   cell_fields_type cell_fields;

   // Take a byte whenever the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Clamp the configured geometry
   always_comb begin
      priority if (channel_count_ff == 6'd0) begin
         chans = 6'd1;
      end else if (channel_count_ff > 6'(CHAN_LIMIT)) begin
         chans = 6'(CHAN_LIMIT);
      end else begin
         chans = channel_count_ff;
      end
      priority if (row_count_ff == 9'd0) begin
         rows = 9'd1;
      end else if (row_count_ff > 9'(ROW_LIMIT)) begin
         rows = 9'(ROW_LIMIT);
      end else begin
         rows = row_count_ff;
      end
   end

   // Parse one byte: pattern start first, then lead byte or next field
   always_comb begin
      pending_in    = pending_ff;
      cell_open_in  = cell_open_ff;
      channel_in    = channel_ff;
      row_in        = row_ff;
      done_in       = done_ff;
      note_in       = note_ff;
      instrument_in = instrument_ff;
      volume_in     = volume_ff;
      effect_in     = effect_ff;
      emit          = 1'b0;
      argument      = 8'd0;

      if (req_pattern_start) begin
         pending_in    = 5'd0;
         cell_open_in  = 1'b0;
         channel_in    = 5'd0;
         row_in        = 8'd0;
         done_in       = 1'b0;
         note_in       = 8'd0;
         instrument_in = INSTRUMENT_NONE;
         volume_in     = 8'd0;
         effect_in     = 8'd0;
      end

      if (!done_in) begin
         if (!cell_open_in) begin
            // lead byte: a flag byte or the note itself
            if (req_data_byte[FLAG_MARKER]) begin
               pending_in = req_data_byte[4:0];
            end else begin
               note_in    = req_data_byte;
               pending_in = FIELDS_AFTER_NOTE;
            end
            if (pending_in == 5'd0) begin
               emit = 1'b1;
            end else begin
               cell_open_in = 1'b1;
            end
         end else begin
            // store the lowest pending field; the cell closes once none are pending
            priority if (pending_in[FLAG_NOTE]) begin
               pending_in[FLAG_NOTE] = 1'b0;
               note_in = req_data_byte;
            end else if (pending_in[FLAG_INSTRUMENT]) begin
               pending_in[FLAG_INSTRUMENT] = 1'b0;
               instrument_in = req_data_byte;
            end else if (pending_in[FLAG_VOLUME]) begin
               pending_in[FLAG_VOLUME] = 1'b0;
               volume_in = req_data_byte;
            end else if (pending_in[FLAG_EFFECT]) begin
               pending_in[FLAG_EFFECT] = 1'b0;
               effect_in = req_data_byte;
            end else begin
               pending_in = 5'd0;
               argument   = req_data_byte;
            end
            if (pending_in == 5'd0) begin
               emit = 1'b1;
            end
         end
      end
   end

   // Decode the cell from the bytes as they stand after this beat
   tpu_cell_format u_cell_format (
      .note_byte       (note_in),
      .instrument_byte (instrument_in),
      .volume_byte     (volume_in),
      .effect_byte     (effect_in),
      .argument_byte   (argument),
      .fields          (cell_fields)
   );

   assign last_channel = ({1'b0, channel_in} + 6'd1) >= chans;
   assign last_row     = ({1'b0, row_in} + 9'd1) >= rows;

   // Hold the result until taken, load a new one on an emitting beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= 6'd1;
         row_count_ff     <= 9'd64;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_write_data[5:0];
            CSR_ROW_COUNT:     row_count_ff     <= csr_write_data;
         endcase
      end
   end

   // Parse state: advance the position and clear the cell on emit
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= 5'd0;
         cell_open_ff  <= 1'b0;
         channel_ff    <= 5'd0;
         row_ff        <= 8'd0;
         done_ff       <= 1'b0;
         note_ff       <= 8'd0;
         instrument_ff <= INSTRUMENT_NONE;
         volume_ff     <= 8'd0;
         effect_ff     <= 8'd0;
      end else if (accept) begin
         if (emit) begin
            pending_ff    <= 5'd0;
            cell_open_ff  <= 1'b0;
            note_ff       <= 8'd0;
            instrument_ff <= INSTRUMENT_NONE;
            volume_ff     <= 8'd0;
            effect_ff     <= 8'd0;
            done_ff       <= done_in;
            if (last_channel) begin
               channel_ff <= 5'd0;
               if (last_row) begin
                  done_ff <= 1'b1;
                  row_ff  <= row_in;
               end else begin
                  row_ff <= row_in + 8'd1;
               end
            end else begin
               channel_ff <= channel_in + 5'd1;
               row_ff     <= row_in;
            end
         end else begin
            pending_ff    <= pending_in;
            cell_open_ff  <= cell_open_in;
            channel_ff    <= channel_in;
            row_ff        <= row_in;
            done_ff       <= done_in;
            note_ff       <= note_in;
            instrument_ff <= instrument_in;
            volume_ff     <= volume_in;
            effect_ff     <= effect_in;
         end
      end
   end

   // Result register: valid under reset, payload without
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_row_ff     <= row_in;
         rsp_channel_ff <= channel_in;
         rsp_last_ff    <= last_channel && last_row;
         rsp_cell_ff    <= cell_fields;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_row_index          = rsp_row_ff;
   assign rsp_channel_index      = rsp_channel_ff;
   assign rsp_note_kind          = rsp_cell_ff.note_kind;
   assign rsp_note_value         = rsp_cell_ff.note_value;
   assign rsp_instrument_present = rsp_cell_ff.instrument_present;
   assign rsp_instrument_value   = rsp_cell_ff.instrument_value;
   assign rsp_volume_set         = rsp_cell_ff.volume_set;
   assign rsp_volume_value       = rsp_cell_ff.volume_value;
   assign rsp_effect_kind        = rsp_cell_ff.effect_kind;
   assign rsp_effect_argument    = rsp_cell_ff.effect_argument;
   assign rsp_last_of_pattern    = rsp_last_ff;

   // A cell is open exactly while fields are still owed
   `TPU_ASSERT_NOW(a_open_matches_pending, 1'b1, cell_open_ff == (pending_ff != 5'd0), "cell open flag disagrees with pending fields")
   // The final cell of a pattern closes the pattern
   `TPU_ASSERT_NEXT(a_last_closes_pattern, accept && emit && last_channel && last_row, done_ff && rsp_valid_ff && rsp_last_ff, "final cell did not close the pattern")
   // A waiting result blocks the byte stream
   `TPU_ASSERT_NOW(a_stall_blocks_input, rsp_valid_ff && !rsp_ready, !req_ready, "byte taken while a result was stalled")

endmodule
